### src/kiht_pkg.sv
// Package: types and constants shared by the key interning hash table.
`timescale 1ns / 1ps
package kiht_pkg;
   localparam int SLOTS        = 1024;
   localparam int KEY_BITS     = 64;
   localparam int SLOT_W       = $clog2(SLOTS);
   localparam int KEY_CAPACITY = SLOTS - SLOTS / 4;
   localparam int ID_W         = $clog2(KEY_CAPACITY);
   localparam int CNT_W        = $clog2(KEY_CAPACITY + 1);
   localparam int SLOT_CNT_W   = $clog2(SLOTS + 1);
   localparam logic [ID_W-1:0] ID_EMPTY = '1;

   localparam logic [1:0] FUNC_FIND  = 2'd0;
   localparam logic [1:0] FUNC_GET   = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;
   localparam logic [1:0] FUNC_RSVD  = 2'd3;

   typedef struct packed {
      logic [1:0]          func;
      logic [KEY_BITS-1:0] key;
      logic [31:0]         key_hash;
   } req_type;

   typedef struct packed {
      logic            found;
      logic [9:0]      key_id;
      logic            inserted;
      logic            status;
   } rsp_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;      // capture request, aim probe at home slot
      logic advance;   // step probe index
      logic insert;    // write slot and key store, bump count
      logic clr_step;  // clear one slot
      logic clr_start; // aim clear pointer at slot zero
      logic respond;   // drive response strobe
      logic hit;       // response is a hit
      logic refuse;    // response is table full
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic slot_empty;
      logic hash_match;
      logic key_match;
      logic walked_all;
      logic table_full;
      logic clr_done;
   } sts_type;
endpackage

### src/kiht_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module kiht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem_ff[addr] <= wdata;
      rdata <= mem_ff[addr];
   end
endmodule

### src/kiht_datapath.sv
// Datapath: slot and key memories, probe pointer, count and compares.
`timescale 1ns / 1ps
module kiht_datapath import kiht_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [3:0] csr_wdata,
   input  req_type    req,
   input  cmd_type    cmd,
   output sts_type    sts,
   output rsp_type    rsp_in
);
   localparam int SW = 32 + ID_W;

   req_type               req_ff;
   logic [3:0]            kb_ff;
   logic [SLOT_W-1:0]     idx_ff, idx_in;
   logic [SLOT_CNT_W-1:0] walked_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [SLOT_W-1:0]     clr_ff;
   logic                  clr_done_ff;

   logic [KEY_BITS-1:0] mask;
   logic [SW-1:0]       slot_rd, slot_wd;
   logic [KEY_BITS-1:0] key_rd;
   logic                slot_we, key_we;
   logic [SLOT_W-1:0]   slot_addr;
   logic [ID_W-1:0]     key_addr, sid;
   logic [3:0]          nb;

   always_comb begin
      nb = kb_ff;
      if (nb == 4'd0) nb = 4'd1;
      if (nb > 4'd8) nb = 4'd8;
      for (int i = 0; i < KEY_BITS; i++) mask[i] = (i < 8 * int'(nb));
   end

   assign sid = slot_rd[ID_W-1:0];
   assign slot_we = cmd.insert || cmd.clr_step;
   assign slot_addr = cmd.clr_step ? clr_ff : (cmd.load ? idx_in : idx_ff);
   assign slot_wd = cmd.clr_step ? {32'd0, ID_EMPTY} : {req_ff.key_hash, cnt_ff[ID_W-1:0]};
   assign key_we = cmd.insert;
   assign key_addr = cmd.insert ? cnt_ff[ID_W-1:0] : sid;
   assign idx_in = req.key_hash[SLOT_W-1:0];

   kiht_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_slot (
      .clock, .we(slot_we), .addr(slot_addr), .wdata(slot_wd), .rdata(slot_rd));
   kiht_ram #(.WIDTH(KEY_BITS), .DEPTH(KEY_CAPACITY)) u_key (
      .clock, .we(key_we), .addr(key_addr), .wdata(req_ff.key & mask), .rdata(key_rd));

   assign sts.slot_empty = (sid == ID_EMPTY) || (int'(sid) >= KEY_CAPACITY);
   assign sts.hash_match = slot_rd[SW-1:ID_W] == req_ff.key_hash;
   assign sts.key_match  = ((key_rd ^ req_ff.key) & mask) == '0;
   assign sts.walked_all = walked_ff == SLOT_CNT_W'(SLOTS);
   assign sts.table_full = cnt_ff >= CNT_W'(KEY_CAPACITY);
   assign sts.clr_done   = clr_done_ff;

   always_comb begin
      rsp_in = '0;
      if (cmd.hit) begin
         rsp_in.found = 1'b1;
         rsp_in.key_id = 10'(sid);
      end else if (cmd.insert) begin
         rsp_in.found = 1'b1;
         rsp_in.inserted = 1'b1;
         rsp_in.key_id = 10'(cnt_ff);
      end else if (cmd.refuse) rsp_in.status = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req;
         idx_ff <= idx_in;
         walked_ff <= '0;
      end else if (cmd.advance) begin
         idx_ff <= idx_ff + 1'b1;
         walked_ff <= walked_ff + 1'b1;
      end
      if (reset) begin
         kb_ff <= 4'd8;
         cnt_ff <= '0;
         clr_ff <= '0;
         clr_done_ff <= 1'b0;
      end else begin
         if (csr_we) kb_ff <= csr_wdata;
         if (cmd.insert) cnt_ff <= cnt_ff + 1'b1;
         if (cmd.clr_start) begin
            clr_ff <= '0;
            clr_done_ff <= 1'b0;
            cnt_ff <= '0;
         end else if (cmd.clr_step) begin
            clr_ff <= clr_ff + 1'b1;
            clr_done_ff <= (clr_ff == SLOT_W'(SLOTS - 1));
         end
      end
   end
endmodule

### src/kiht_ctrl.sv
// Controller: sequences clearing, probing and insertion.
`timescale 1ns / 1ps
module kiht_ctrl import kiht_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] func,
   input  sts_type    sts,
   output cmd_type    cmd,
   output logic       busy
);
   typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_WAIT, S_CHECK, S_CLRRSP}
      state_type;
   state_type state_ff, state_in;
   logic [1:0] func_ff;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      busy = state_ff != S_IDLE;
      unique case (state_ff)
         S_CLEAR: begin
            if (sts.clr_done) state_in = S_CLRRSP;
            else cmd.clr_step = 1'b1;
         end
         S_CLRRSP: state_in = S_IDLE;
         S_IDLE: begin
            if (start) begin
               if (func == FUNC_CLEAR) begin
                  cmd.clr_start = 1'b1;
                  state_in = S_CLEAR;
               end else if (func == FUNC_FIND || func == FUNC_GET) begin
                  cmd.load = 1'b1;
                  state_in = S_READ;
               end else cmd.respond = 1'b1;
            end
         end
         S_READ: state_in = S_WAIT;   // slot data lands
         S_WAIT: begin
            // Slot word is valid; fetch the key for its id.
            if (sts.walked_all || sts.slot_empty) begin
               cmd.respond = 1'b1;
               state_in = S_IDLE;
               if (func_ff == FUNC_GET) begin
                  if (sts.table_full || sts.walked_all) cmd.refuse = 1'b1;
                  else cmd.insert = 1'b1;
               end
            end else if (!sts.hash_match) begin
               cmd.advance = 1'b1;
               state_in = S_READ;
            end else state_in = S_CHECK;
         end
         S_CHECK: begin
            if (sts.key_match) begin
               cmd.respond = 1'b1;
               cmd.hit = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.advance = 1'b1;
               state_in = S_READ;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         func_ff <= FUNC_FIND;
      end else begin
         state_ff <= state_in;
         if (cmd.load) func_ff <= func;
      end
   end
endmodule

### src/key_interning_hash_table_unit.sv
// Top level of the key interning hash table.
//
// A request beat (op, key, hash) is taken when start is high and busy low.
// Exactly one response beat follows, shown for one cycle with rsp_valid;
// the receiver cannot stall it.
// Find and get-or-insert probe linearly from the home slot (hash modulo the
// slot count): each probe reads the slot word (S_READ, S_WAIT) and, when
// the stored hash matches, the stored key as well (S_CHECK); both RAMs
// have a registered read.
// Busy drops as a find/get response is registered (a clear's comes while busy
// is high), so no request is taken before the edge that takes the last response.
// Clear sweeps the slot RAM one slot a cycle, then answers with all fields
// zero. Reset runs the same sweep with busy high and gives no response; csr
// writes are taken at any time outside reset.
// csr_we loads the key byte count; unused op code 3 answers at once, zero.
`timescale 1ns / 1ps
module key_interning_hash_table_unit import kiht_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   output logic       rsp_valid,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [3:0] csr_wdata
);
   cmd_type cmd;
   sts_type sts;
   rsp_type rsp_in;
   logic    clr_rsp_ff;

   kiht_ctrl u_ctrl (.clock, .reset, .start, .func(req_data.func), .sts, .cmd, .busy);
   kiht_datapath u_dp (.clock, .reset, .csr_we, .csr_wdata, .req(req_data),
      .cmd, .sts, .rsp_in);

   // Clear answers after its sweep; reset's sweep does not.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
         clr_rsp_ff <= 1'b0;
      end else begin
         if (cmd.clr_start) clr_rsp_ff <= 1'b1;
         else if (sts.clr_done) clr_rsp_ff <= 1'b0;
         rsp_valid <= cmd.respond || (sts.clr_done && clr_rsp_ff && !cmd.clr_step);
      end
      rsp_data <= cmd.respond ? rsp_in : '0;
   end
endmodule

### src/kiht_checker.sv
// Port-level checker for the key interning hash table, with its bind.
`timescale 1ns / 1ps
module kiht_checker import kiht_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);
   a_ins_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.inserted |-> rsp_data.found && !rsp_data.status)
      else $error("inserted without found");
   a_full_nofound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status |-> !rsp_data.found && rsp_data.key_id == '0)
      else $error("full response carries an id");
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> !rsp_data.inserted && rsp_data.key_id == '0)
      else $error("miss response carries an id");
   a_busy_after_reset: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> busy)
      else $error("not busy while the table is swept after reset");
endmodule

bind key_interning_hash_table_unit kiht_checker u_kiht_checker (
   .clock, .reset, .busy, .rsp_valid, .rsp_data);

### tb/tb_key_interning_hash_table_unit.sv
// Testbench for the key interning hash table: directed and random beats against a predictor.
`timescale 1ns / 1ps
module tb_key_interning_hash_table_unit;
   import kiht_pkg::*;

   class intern_scoreboard;
      logic [31:0] slot_hash_q [SLOTS];
      int          slot_id_q   [SLOTS];
      bit          slot_used_q [SLOTS];
      logic [63:0] stored_key  [KEY_CAPACITY];
      int          key_total;
      int          key_len;
      rsp_type     pending [$];
      int          mismatches;

      function void reset_state();
         foreach (slot_used_q[i]) slot_used_q[i] = 0;
         key_total = 0;
         key_len = 8;
      endfunction

      function logic [63:0] key_mask();
         int nb;
         nb = key_len;
         if (nb < 1) nb = 1;
         if (nb > 8) nb = 8;
         if (nb == 8) return '1;
         return (64'd1 << (nb * 8)) - 64'd1;
      endfunction

      // Notes one accepted request beat and queues the response it must produce.
      function void note_request(req_type r);
         rsp_type     res;
         logic [63:0] m;
         int          idx, n, where;
         bit          hit;
         res = '0;
         m = key_mask();
         if (r.func == FUNC_CLEAR) begin
            foreach (slot_used_q[i]) slot_used_q[i] = 0;
            key_total = 0;
         end else if (r.func == FUNC_FIND || r.func == FUNC_GET) begin
            idx = r.key_hash % SLOTS;
            where = SLOTS;
            hit = 0;
            for (n = 0; n < SLOTS; n++) begin
               if (!slot_used_q[idx]) begin
                  where = idx;
                  break;
               end
               if (slot_hash_q[idx] == r.key_hash &&
                   ((stored_key[slot_id_q[idx]] ^ r.key) & m) == 0) begin
                  where = idx;
                  hit = 1;
                  break;
               end
               idx = (idx + 1) % SLOTS;
            end
            if (hit) begin
               res.found = 1;
               res.key_id = 10'(slot_id_q[where]);
            end else if (r.func == FUNC_GET) begin
               if (key_total >= KEY_CAPACITY || where >= SLOTS) begin
                  res.status = 1;
               end else begin
                  stored_key[key_total] = r.key & m;
                  slot_hash_q[where] = r.key_hash;
                  slot_id_q[where] = key_total;
                  slot_used_q[where] = 1;
                  res.key_id = 10'(key_total);
                  res.found = 1;
                  res.inserted = 1;
                  key_total++;
               end
            end
         end
         pending.push_back(res);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected response %p", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
         end
      endfunction
   endclass

   logic       clock = 0;
   logic       reset = 1;
   logic       start = 0;
   logic       busy;
   req_type    req_data = '0;
   logic       rsp_valid;
   rsp_type    rsp_data;
   logic       csr_we = 0;
   logic [3:0] csr_wdata = '0;

   intern_scoreboard board = new();
   int send_idle_pct = 0;
   logic [63:0] key_pool [32];
   logic [31:0] hash_pool [32];

   key_interning_hash_table_unit uut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   always @(posedge clock)
      if (!reset && rsp_valid) board.check_response(rsp_data);

   initial begin
      #100_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Start stays high between back-to-back beats; it drops only while idling.
   task automatic send_beat(logic [1:0] f, logic [63:0] k, logic [31:0] h);
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 0;
         @(negedge clock);
      end
      start <= 1;
      req_data <= '{func: f, key: k, key_hash: h};
      while (busy) @(negedge clock);
      @(posedge clock);
      board.note_request(req_data);
      @(negedge clock);
   endtask

   task automatic drain();
      start <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_key_len(int v);
      drain();
      csr_we <= 1;
      csr_wdata <= v[3:0];
      @(negedge clock);
      csr_we <= 0;
      board.key_len = v;
   endtask

   // Mostly reuse a small pool of keys so lookups hit; shared hashes force probe chains.
   task automatic random_beat();
      int          p, r;
      logic [1:0]  f;
      logic [63:0] k;
      logic [31:0] h;
      p = $urandom_range(31);
      r = $urandom_range(99);
      f = (r < 45) ? FUNC_GET : (r < 90) ? FUNC_FIND : (r < 93) ? FUNC_CLEAR : FUNC_RSVD;
      if ($urandom_range(3) == 0) begin
         k = {$urandom, $urandom};
         h = $urandom_range(3) == 0 ? hash_pool[p] : $urandom;
      end else begin
         k = key_pool[p];
         h = hash_pool[p];
      end
      send_beat(f, k, h);
   endtask

   initial begin
      int i;
      board.reset_state();
      for (i = 0; i < 32; i++) begin
         key_pool[i] = {$urandom, $urandom};
         hash_pool[i] = (i < 8) ? 32'h0000_03ff + i / 2 : $urandom;
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: extremes, every operation, collisions and wrap-around.
      send_beat(FUNC_FIND, '1, '1);
      send_beat(FUNC_GET, '1, '1);
      send_beat(FUNC_GET, '0, '1);
      send_beat(FUNC_GET, '0, '0);
      send_beat(FUNC_FIND, '1, '1);
      send_beat(FUNC_FIND, '0, '1);
      send_beat(FUNC_GET, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA);
      send_beat(FUNC_GET, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555);
      send_beat(FUNC_RSVD, '1, '1);
      send_beat(FUNC_FIND, 64'h1, 32'h0);
      set_key_len(1);
      send_beat(FUNC_FIND, 64'hFFFF_FFFF_FFFF_FF00, 32'h0);
      send_beat(FUNC_GET, 64'h1234, 32'h3ff);
      send_beat(FUNC_FIND, 64'h9934, 32'h3ff);
      set_key_len(0);
      send_beat(FUNC_FIND, 64'h34, 32'h3ff);
      set_key_len(15);
      send_beat(FUNC_FIND, 64'h34, 32'h3ff);
      send_beat(FUNC_CLEAR, '1, '1);
      send_beat(FUNC_FIND, '1, '1);
      set_key_len(8);
      // A run of distinct keys whose home slots cross the end of the table.
      for (i = 0; i < 100; i++) send_beat(FUNC_GET, 64'(i), 32'(i * 3 + 1020));
      send_beat(FUNC_GET, 64'hDEAD, 32'h7);
      send_beat(FUNC_FIND, 64'd5, 32'd1035);
      send_beat(FUNC_CLEAR, '0, '0);

      send_idle_pct = 34;
      for (i = 0; i < 180; i++) random_beat();
      drain();
      set_key_len(3);
      send_idle_pct = 85;
      for (i = 0; i < 180; i++) random_beat();
      drain();
      set_key_len(8);
      send_idle_pct = 0;
      for (i = 0; i < 170; i++) random_beat();
      drain();

      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
